/* rtl/core/char_lcd_nibble_sequencer_core_assert.svh */
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core_assert.svh
// assertion macros used by the checker file of the sequencer
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_CORE_ASSERT_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define CLNS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("clns assertion failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define CLNS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("clns assertion failed");

`endif

/* rtl/core/clns_pkg.sv */
// ----------------------------------------------------------------------------
// clns_pkg
// types, constants and strobe tables of the four-bit display sequencer
// ----------------------------------------------------------------------------
package clns_pkg;

  // request kinds
  typedef enum logic [1:0] {
    MODE_INIT   = 2'd0,
    MODE_CMD    = 2'd1,
    MODE_DATA   = 2'd2,
    MODE_CURSOR = 2'd3
  } mode_e;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POWERUP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_WAKE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_HIGH = 3'd4;
  localparam int unsigned CFG_DATA_W = 16;

  // register reset values
  localparam logic [15:0] SETTLE_RST     = 16'd100;
  localparam logic [15:0] POWERUP_RST    = 16'd50000;
  localparam logic [15:0] FIRST_WAKE_RST = 16'd5000;
  localparam logic [15:0] CLEAR_RST      = 16'd2000;
  localparam logic [7:0]  PULSE_HIGH_RST = 8'd1;

  // strobe counting
  localparam int unsigned IDX_W = 4;
  localparam logic [IDX_W-1:0] INIT_LAST_IDX = 4'd11;
  localparam logic [IDX_W-1:0] BYTE_LAST_IDX = 4'd1;

  // display constants
  localparam logic [7:0] CURSOR_CMD = 8'h80;
  localparam logic [6:0] LINE1_BASE = 7'h40;

  // extra wait added to settle after a strobe
  typedef enum logic [1:0] {
    EXTRA_NONE,
    EXTRA_SETTLE,
    EXTRA_FIRST_WAKE,
    EXTRA_CLEAR
  } extra_e;

  // controller to datapath commands
  typedef struct packed {
    logic             load;
    logic             emit;
    logic [IDX_W-1:0] idx;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
    logic strobe_last;
  } dp_stat_t;

  // init nibble sequence: wake 3,3,3,2 then 0x28, 0x0C, 0x06, 0x01
  function automatic logic [3:0] init_nibble(input logic [IDX_W-1:0] idx);
    logic [3:0] nib;
    case (idx)
      4'd0, 4'd1, 4'd2: nib = 4'h3;
      4'd3, 4'd4:       nib = 4'h2;
      4'd5:             nib = 4'h8;
      4'd6:             nib = 4'h0;
      4'd7:             nib = 4'hC;
      4'd8:             nib = 4'h0;
      4'd9:             nib = 4'h6;
      4'd10:            nib = 4'h0;
      4'd11:            nib = 4'h1;
      default:          nib = 4'h0;
    endcase
    return nib;
  endfunction

  // extra wait for each init strobe
  function automatic extra_e init_extra(input logic [IDX_W-1:0] idx);
    extra_e ex;
    case (idx)
      4'd0:             ex = EXTRA_FIRST_WAKE;
      4'd1, 4'd2, 4'd3: ex = EXTRA_SETTLE;
      4'd11:            ex = EXTRA_CLEAR;
      default:          ex = EXTRA_NONE;
    endcase
    return ex;
  endfunction

endpackage

/* rtl/core/clns_ctrl.sv */
// ----------------------------------------------------------------------------
// clns_ctrl
// request controller: takes a request and steps through its strobes
// ----------------------------------------------------------------------------
module clns_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  clns_pkg::dp_stat_t    stat_i,
  output clns_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e                     state_q;
  logic [clns_pkg::IDX_W-1:0] idx_q;

  // commands to the datapath
  always_comb begin
    req_ready_o = (state_q == ST_IDLE);
    cmd_o.load  = (state_q == ST_IDLE) && req_valid_i;
    cmd_o.emit  = (state_q == ST_RUN) && stat_i.out_free;
    cmd_o.idx   = idx_q;
  end

  // state and strobe counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (req_valid_i) begin
            state_q <= ST_RUN;
            idx_q   <= '0;
          end
        end
        ST_RUN: begin
          if (stat_i.out_free) begin
            if (stat_i.strobe_last) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/clns_datapath.sv */
// ----------------------------------------------------------------------------
// clns_datapath
// config registers, request latch, strobe formation and output register
// ----------------------------------------------------------------------------
module clns_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write
  input  logic                              cfg_we_i,
  input  logic [clns_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [clns_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // request fields
  input  logic [1:0]                        mode_i,
  input  logic [7:0]                        byte_value_i,
  input  logic                              row_i,
  input  logic [5:0]                        col_i,
  // control
  input  clns_pkg::ctrl_cmd_t               cmd_i,
  output clns_pkg::dp_stat_t                stat_o,
  // strobe output
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              reg_select_o,
  output logic [3:0]                        nibble_o,
  output logic [15:0]                       lead_us_o,
  output logic [7:0]                        high_us_o,
  output logic [15:0]                       after_us_o,
  output logic                              last_o
);

  logic [15:0] settle_q, powerup_q, first_wake_q, clear_q;
  logic [7:0]  pulse_high_q;

  clns_pkg::mode_e mode_q;
  logic [7:0]      byte_q;
  logic            row_q;
  logic [5:0]      col_q;

  logic        out_valid_q;
  logic        rs_q, last_q;
  logic [3:0]  nib_q;
  logic [15:0] lead_q, after_q;
  logic [7:0]  high_q;

  logic            is_init;
  logic [6:0]      addr;
  logic [7:0]      send_byte;
  logic [3:0]      nib_d;
  clns_pkg::extra_e extra_sel;
  logic [15:0]     extra;
  logic [16:0]     after_sum;
  logic [15:0]     after_d, lead_d;
  logic [7:0]      high_d;
  logic            strobe_last;
  logic            out_free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q     <= clns_pkg::SETTLE_RST;
      powerup_q    <= clns_pkg::POWERUP_RST;
      first_wake_q <= clns_pkg::FIRST_WAKE_RST;
      clear_q      <= clns_pkg::CLEAR_RST;
      pulse_high_q <= clns_pkg::PULSE_HIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        clns_pkg::REG_SETTLE:     settle_q     <= cfg_data_i;
        clns_pkg::REG_POWERUP:    powerup_q    <= cfg_data_i;
        clns_pkg::REG_FIRST_WAKE: first_wake_q <= cfg_data_i;
        clns_pkg::REG_CLEAR:      clear_q      <= cfg_data_i;
        clns_pkg::REG_PULSE_HIGH: pulse_high_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= clns_pkg::mode_e'(mode_i);
      byte_q <= byte_value_i;
      row_q  <= row_i;
      col_q  <= col_i;
    end
  end

  // byte to send and its nibble for this strobe
  always_comb begin
    is_init = (mode_q == clns_pkg::MODE_INIT);
    addr    = (row_q ? clns_pkg::LINE1_BASE : 7'h00) + {1'b0, col_q};
    case (mode_q)
      clns_pkg::MODE_CMD,
      clns_pkg::MODE_DATA:   send_byte = byte_q;
      clns_pkg::MODE_CURSOR: send_byte = clns_pkg::CURSOR_CMD | {1'b0, addr};
      default:               send_byte = 8'h00;
    endcase
    if (is_init) begin
      nib_d       = clns_pkg::init_nibble(cmd_i.idx);
      extra_sel   = clns_pkg::init_extra(cmd_i.idx);
      strobe_last = (cmd_i.idx == clns_pkg::INIT_LAST_IDX);
    end else begin
      nib_d       = cmd_i.idx[0] ? send_byte[3:0] : send_byte[7:4];
      extra_sel   = clns_pkg::EXTRA_NONE;
      strobe_last = (cmd_i.idx == clns_pkg::BYTE_LAST_IDX);
    end
  end

  // waits and enable time, after wait saturates
  always_comb begin
    case (extra_sel)
      clns_pkg::EXTRA_SETTLE:     extra = settle_q;
      clns_pkg::EXTRA_FIRST_WAKE: extra = first_wake_q;
      clns_pkg::EXTRA_CLEAR:      extra = clear_q;
      default:                    extra = 16'h0000;
    endcase
    after_sum = {1'b0, settle_q} + {1'b0, extra};
    after_d   = after_sum[16] ? 16'hFFFF : after_sum[15:0];
    lead_d    = (is_init && (cmd_i.idx == '0)) ? powerup_q : 16'h0000;
    high_d    = (pulse_high_q == 8'h00) ? 8'h01 : pulse_high_q;
  end

  assign out_free = !out_valid_q || out_ready_i;

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= cmd_i.emit;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit && out_free) begin
      rs_q    <= (mode_q == clns_pkg::MODE_DATA);
      nib_q   <= nib_d;
      lead_q  <= lead_d;
      high_q  <= high_d;
      after_q <= after_d;
      last_q  <= strobe_last;
    end
  end

  assign stat_o.out_free    = out_free;
  assign stat_o.strobe_last = strobe_last;

  assign out_valid_o  = out_valid_q;
  assign reg_select_o = rs_q;
  assign nibble_o     = nib_q;
  assign lead_us_o    = lead_q;
  assign high_us_o    = high_q;
  assign after_us_o   = after_q;
  assign last_o       = last_q;

endmodule

/* rtl/core/char_lcd_nibble_sequencer_core.sv */
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core
// four-bit character display sequencer: one request in, a run of strobes out
// ----------------------------------------------------------------------------
// Requests come in on the s_axis channel: init, command byte, data byte or
// set cursor. Each request produces a run of enable strobes on the m_axis
// channel, one strobe per transfer; tlast marks the final strobe of a run and
// tuser carries the register-select level. Init yields twelve strobes, every
// other request two (high nibble first).
// A taken request moves the controller into its run state, which loads the
// first strobe into the output register; after that one strobe is loaded per
// cycle while the receiver takes them. The controller walks one strobe index
// per cycle while the output register is free and holds one request at a time;
// s_axis_tready rises again once the final strobe is in the output register.
// When the receiver stalls, the output register holds its strobe and the
// controller waits on it. Reset clears the controller and output valid and
// loads the timing registers with defaults (settle 100, power-up 50000, first
// wake 5000, clear 2000, enable high 1). Config writes act on the next clock
// edge; the user, not the block, keeps them to when no request is in flight.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // mode[1:0], byte_value[9:2], row[10], col[16:11]
  // strobes
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // nibble[3:0], lead_us[19:4], high_us[27:20],
                                      // after_us[43:28]
  output logic        m_axis_tuser,   // reg_select
  output logic        m_axis_tlast    // last
);

  clns_pkg::ctrl_cmd_t cmd;
  clns_pkg::dp_stat_t  stat;

  logic [3:0]  nibble;
  logic [15:0] lead_us, after_us;
  logic [7:0]  high_us;

  // controller
  clns_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath
  clns_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .mode_i       (s_axis_tdata[1:0]),
    .byte_value_i (s_axis_tdata[9:2]),
    .row_i        (s_axis_tdata[10]),
    .col_i        (s_axis_tdata[16:11]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .reg_select_o (m_axis_tuser),
    .nibble_o     (nibble),
    .lead_us_o    (lead_us),
    .high_us_o    (high_us),
    .after_us_o   (after_us),
    .last_o       (m_axis_tlast)
  );

  // pack strobe fields, zero fill to whole bytes
  assign m_axis_tdata = {4'h0, after_us, high_us, lead_us, nibble};

endmodule

/* rtl/core/clns_checker.sv */
// ----------------------------------------------------------------------------
// clns_checker
// port-level checks of the sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "char_lcd_nibble_sequencer_core_assert.svh"

module clns_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // a taken request keeps the block busy in the next cycle
  `CLNS_ASSERT_NEXT(a_busy_after_request, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // while a strobe that is not the last of its run waits, no request is taken
  `CLNS_ASSERT_IMPL(a_no_request_mid_run, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

  // enable high time is never zero
  `CLNS_ASSERT_IMPL(a_high_nonzero, m_axis_tvalid, m_axis_tdata[27:20] != 8'h00)

  // a stalled strobe holds its payload
  `CLNS_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready,
                    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

endmodule

bind char_lcd_nibble_sequencer_core clns_checker u_clns_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

/* sim/char_lcd_strobe_monitor.sv */
// ----------------------------------------------------------------------------
// char_lcd_strobe_monitor
// watches the request and strobe channels and checks every strobe
// ----------------------------------------------------------------------------
// Keeps its own copy of the timing registers by snooping the write port.
// Each accepted request is expanded into the strobe run it should produce,
// and the runs are queued in order. Each strobe taken on the master side is
// compared with the oldest queued strobe. The error count and the number of
// strobes still owed go back to the top level.
// ----------------------------------------------------------------------------
module char_lcd_strobe_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // mode, byte_value, row, col
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,   // nibble, lead_us, high_us, after_us
  input  logic        m_axis_tuser,   // reg_select
  input  logic        m_axis_tlast,
  output int          err_cnt_o,
  output int          owed_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // init wake nibbles and commands, cursor address parts
  localparam logic [3:0] NIB_WAKE        = 4'h3;
  localparam logic [3:0] NIB_FOUR_BIT    = 4'h2;
  localparam logic [7:0] CMD_FUNC_SET    = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0C;
  localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
  localparam logic [7:0] CMD_CLEAR       = 8'h01;
  localparam logic [7:0] CMD_SET_ADDR    = 8'h80;
  localparam logic [7:0] LINE1_OFFSET    = 8'h40;
  localparam int         MAX_REPORTS     = 10;

  typedef struct packed {
    logic        rs;
    logic [3:0]  nib;
    logic [15:0] lead_us;
    logic [7:0]  high_us;
    logic [15:0] after_us;
    logic        last;
  } strobe_t;

  strobe_t     owed_strobes[$];
  logic [15:0] settle_us;
  logic [15:0] powerup_us;
  logic [15:0] first_wake_us;
  logic [15:0] clear_us;
  logic [7:0]  pulse_high_us;
  int          err_cnt;

  // one strobe at the current timing, the settle sum saturating at 16 bits
  function automatic strobe_t form_strobe(logic rs, logic [3:0] nib, logic [15:0] lead,
                                          logic [16:0] wait_sum, logic last);
    strobe_t s;
    s.rs       = rs;
    s.nib      = nib;
    s.lead_us  = lead;
    s.high_us  = (pulse_high_us == 8'd0) ? 8'd1 : pulse_high_us;
    s.after_us = wait_sum[16] ? 16'hFFFF : wait_sum[15:0];
    s.last     = last;
    return s;
  endfunction

  // a byte goes out high nibble first
  task automatic owe_byte(logic rs, logic [7:0] b, logic [15:0] extra, logic last);
    owed_strobes.push_back(form_strobe(rs, b[7:4], 16'd0, {1'b0, settle_us}, 1'b0));
    owed_strobes.push_back(form_strobe(rs, b[3:0], 16'd0,
                                       {1'b0, settle_us} + {1'b0, extra}, last));
  endtask

  // expand one request into its strobe run
  task automatic predict_strobes(logic [23:0] req);
    clns_pkg::mode_e kind;
    logic [7:0]      b;
    logic            row;
    logic [5:0]      col;
    logic [7:0]      addr;
    logic [16:0]     twice_settle;
    kind         = clns_pkg::mode_e'(req[1:0]);
    b            = req[9:2];
    row          = req[10];
    col          = req[16:11];
    twice_settle = {1'b0, settle_us} + {1'b0, settle_us};
    case (kind)
      clns_pkg::MODE_INIT: begin
        owed_strobes.push_back(form_strobe(1'b0, NIB_WAKE, powerup_us,
                                           {1'b0, settle_us} + {1'b0, first_wake_us},
                                           1'b0));
        owed_strobes.push_back(form_strobe(1'b0, NIB_WAKE, 16'd0, twice_settle, 1'b0));
        owed_strobes.push_back(form_strobe(1'b0, NIB_WAKE, 16'd0, twice_settle, 1'b0));
        owed_strobes.push_back(form_strobe(1'b0, NIB_FOUR_BIT, 16'd0, twice_settle, 1'b0));
        owe_byte(1'b0, CMD_FUNC_SET, 16'd0, 1'b0);
        owe_byte(1'b0, CMD_DISPLAY_ON, 16'd0, 1'b0);
        owe_byte(1'b0, CMD_ENTRY_MODE, 16'd0, 1'b0);
        owe_byte(1'b0, CMD_CLEAR, clear_us, 1'b1);
      end
      clns_pkg::MODE_CMD:  owe_byte(1'b0, b, 16'd0, 1'b1);
      clns_pkg::MODE_DATA: owe_byte(1'b1, b, 16'd0, 1'b1);
      default: begin
        addr = (row ? LINE1_OFFSET : 8'h00) + {2'b00, col};
        owe_byte(1'b0, CMD_SET_ADDR | addr, 16'd0, 1'b1);
      end
    endcase
  endtask

  // snoop writes, predict on each request, compare each strobe
  always @(posedge clk_i or negedge rst_ni) begin
    strobe_t got;
    strobe_t want;
    if (!rst_ni) begin
      settle_us     = 16'd100;
      powerup_us    = 16'd50000;
      first_wake_us = 16'd5000;
      clear_us      = 16'd2000;
      pulse_high_us = 8'd1;
      err_cnt       = 0;
      owed_strobes.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          clns_pkg::REG_SETTLE:     settle_us     = cfg_data_i;
          clns_pkg::REG_POWERUP:    powerup_us    = cfg_data_i;
          clns_pkg::REG_FIRST_WAKE: first_wake_us = cfg_data_i;
          clns_pkg::REG_CLEAR:      clear_us      = cfg_data_i;
          clns_pkg::REG_PULSE_HIGH: pulse_high_us = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_strobes(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{rs: m_axis_tuser, nib: m_axis_tdata[3:0], lead_us: m_axis_tdata[19:4],
                high_us: m_axis_tdata[27:20], after_us: m_axis_tdata[43:28],
                last: m_axis_tlast};
        if (owed_strobes.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%t unexpected strobe rs=%0d nib=%h lead=%0d high=%0d after=%0d last=%0d",
                     $realtime, got.rs, got.nib, got.lead_us, got.high_us, got.after_us,
                     got.last);
        end else begin
          want = owed_strobes.pop_front();
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS) begin
              $display("%t strobe mismatch", $realtime);
              $display("  expected rs=%0d nib=%h lead=%0d high=%0d after=%0d last=%0d",
                       want.rs, want.nib, want.lead_us, want.high_us, want.after_us,
                       want.last);
              $display("  actual   rs=%0d nib=%h lead=%0d high=%0d after=%0d last=%0d",
                       got.rs, got.nib, got.lead_us, got.high_us, got.after_us, got.last);
            end
          end
        end
      end
    end
    err_cnt_o  <= err_cnt;
    owed_cnt_o <= owed_strobes.size();
  end

endmodule

/* sim/char_lcd_nibble_sequencer_core_tb.sv */
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core_tb
// request stimulus and verdict for the four-bit display sequencer
// ----------------------------------------------------------------------------
// Drives a directed set of requests at reset timing, then phases of random
// requests, each under its own timing registers (maximum, zero, minimum,
// defaults and random values) and its own mix of request gaps and strobe
// back-pressure. A strobe monitor beside the block checks every strobe.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // mode, byte_value, row, col
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // nibble, lead_us, high_us, after_us
  logic        m_axis_tuser;   // reg_select
  logic        m_axis_tlast;
  int          err_cnt;
  int          owed_cnt;
  int          gap_pct;
  int          stall_pct;

  char_lcd_nibble_sequencer_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  char_lcd_strobe_monitor u_strobe_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .err_cnt_o    (err_cnt),
    .owed_cnt_o   (owed_cnt)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // strobe back-pressure
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = ($urandom_range(99) >= stall_pct);
    end
  end

  // run limit
  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  // one request, with a random gap ahead of it
  task automatic send_request(clns_pkg::mode_e kind, logic [7:0] b, logic row,
                              logic [5:0] col);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {7'd0, col, row, b, kind};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // hold requests until every owed strobe is out and the block is quiet
  task automatic drain;
    s_axis_tvalid = 1'b0;
    while (owed_cnt != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  // load all timing registers, plus one write past the register list
  task automatic program_timing(logic [15:0] settle, logic [15:0] powerup,
                                logic [15:0] first_wake, logic [15:0] clear,
                                logic [7:0] pulse);
    drain();
    cfg_we_i   = 1'b1;
    cfg_idx_i  = clns_pkg::REG_SETTLE;
    cfg_data_i = settle;
    @(negedge clk_i);
    cfg_idx_i  = clns_pkg::REG_POWERUP;
    cfg_data_i = powerup;
    @(negedge clk_i);
    cfg_idx_i  = clns_pkg::REG_FIRST_WAKE;
    cfg_data_i = first_wake;
    @(negedge clk_i);
    cfg_idx_i  = clns_pkg::REG_CLEAR;
    cfg_data_i = clear;
    @(negedge clk_i);
    cfg_idx_i  = clns_pkg::REG_PULSE_HIGH;
    cfg_data_i = {8'($urandom_range(255)), pulse};
    @(negedge clk_i);
    // unmapped index, must be ignored
    cfg_idx_i  = clns_pkg::REG_PULSE_HIGH + 3'(1 + $urandom_range(2));
    cfg_data_i = 16'($urandom_range(65535));
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    @(negedge clk_i);
  endtask

  // random requests, pausing once mid-phase until all strobes are out
  task automatic run_phase(int gap, int stall, int n_req);
    gap_pct   = gap;
    stall_pct = stall;
    for (int i = 0; i < n_req; i++) begin
      if (i == n_req / 2) drain();
      send_request(clns_pkg::mode_e'($urandom_range(3)), 8'($urandom_range(255)),
                   1'($urandom_range(1)), 6'($urandom_range(63)));
    end
  endtask

  // stimulus and verdict
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = clns_pkg::REG_SETTLE;
    cfg_data_i    = 16'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 24'd0;
    gap_pct       = 0;
    stall_pct     = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed requests at reset timing
    send_request(clns_pkg::MODE_INIT,   8'h00, 1'b0, 6'd0);
    send_request(clns_pkg::MODE_CMD,    8'h00, 1'b0, 6'd0);
    send_request(clns_pkg::MODE_CMD,    8'hFF, 1'b1, 6'd63);
    send_request(clns_pkg::MODE_CMD,    8'hA5, 1'b0, 6'd21);
    send_request(clns_pkg::MODE_DATA,   8'h00, 1'b1, 6'd42);
    send_request(clns_pkg::MODE_DATA,   8'hFF, 1'b0, 6'd0);
    send_request(clns_pkg::MODE_DATA,   8'h5A, 1'b1, 6'd63);
    send_request(clns_pkg::MODE_CURSOR, 8'h00, 1'b0, 6'd0);
    send_request(clns_pkg::MODE_CURSOR, 8'hFF, 1'b1, 6'd0);
    send_request(clns_pkg::MODE_CURSOR, 8'h00, 1'b0, 6'd39);
    send_request(clns_pkg::MODE_CURSOR, 8'h3C, 1'b1, 6'd39);
    // columns past the visible line
    send_request(clns_pkg::MODE_CURSOR, 8'h00, 1'b0, 6'd63);
    send_request(clns_pkg::MODE_CURSOR, 8'h00, 1'b1, 6'd63);
    send_request(clns_pkg::MODE_CURSOR, 8'hC3, 1'b0, 6'd42);
    send_request(clns_pkg::MODE_CURSOR, 8'h00, 1'b1, 6'd21);
    send_request(clns_pkg::MODE_INIT,   8'hFF, 1'b1, 6'd63);
    send_request(clns_pkg::MODE_INIT,   8'h00, 1'b0, 6'd0);
    send_request(clns_pkg::MODE_DATA,   8'h41, 1'b0, 6'd0);
    run_phase(0, 0, 40);

    // saturating waits, widest enable pulse
    program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    run_phase(45, 0, 57);
    // zero settle and zero enable time
    program_timing(16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
    run_phase(0, 45, 57);
    program_timing(16'd1, 16'd1, 16'd0, 16'hFFFF, 8'd1);
    run_phase(20, 20, 57);
    program_timing(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                   16'($urandom_range(65535)), 16'($urandom_range(65535)),
                   8'($urandom_range(255)));
    run_phase(0, 0, 57);
    // doubled settle just past 16 bits
    program_timing(16'd32768, 16'd12345, 16'd40000, 16'd33000, 8'd128);
    run_phase(45, 0, 57);
    program_timing(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                   16'($urandom_range(65535)), 16'($urandom_range(65535)),
                   8'($urandom_range(255)));
    run_phase(0, 45, 57);
    program_timing(16'd100, 16'd50000, 16'd5000, 16'd2000, 8'd1);
    run_phase(20, 20, 57);

    // wait out the last strobes
    s_axis_tvalid = 1'b0;
    while (owed_cnt != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (err_cnt == 0 && owed_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
